/* rtl/bhf_pkg.sv */
// Shared types, constants and helper functions for the binary hole fill block.
// Used by bhf_ctrl, bhf_datapath and binary_hole_fill; depends on nothing else.
package bhf_pkg;

  localparam int ROW_W        = 32;
  localparam int SIDE_W       = 6;
  localparam int DEF_MAX_SIDE = 32;
  localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(32);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PRIME,
    ST_WINDOW,
    ST_ROW,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              wall_we;
    logic [SIDE_W-1:0] wall_addr;
    logic              rd_en;
    logic [SIDE_W-1:0] rd_addr;
    logic              win_load;
    logic              row_step;
    logic              seed;
    logic              in_edge;
    logic              dn_valid;
    logic [SIDE_W-1:0] reach_addr;
    logic              out_load;
    logic              last;
  } cmd_t;

  typedef struct packed {
    logic changed_any;
  } stat_t;

  // Side actually used: at least 1, at most the row width and the storage depth.
  function automatic logic [SIDE_W-1:0] side_in_use(input logic [SIDE_W-1:0] len,
                                                    input int max_side);
    logic [SIDE_W:0] s;
    s = {1'b0, len};
    if (s == '0) s = (SIDE_W+1)'(1);
    if (int'(s) > max_side) s = (SIDE_W+1)'(max_side);
    if (int'(s) > ROW_W) s = (SIDE_W+1)'(ROW_W);
    return s[SIDE_W-1:0];
  endfunction

  function automatic logic [ROW_W-1:0] column_mask(input logic [SIDE_W-1:0] s);
    logic [ROW_W-1:0] m;
    if (int'(s) >= ROW_W) m = '1;
    else m = (ROW_W'(1) << s) - ROW_W'(1);
    return m;
  endfunction

endpackage

/* rtl/bhf_ctrl.sv */
// Controller for the binary hole fill block: load, propagation passes, emission.
// Depends on bhf_pkg; drives bhf_datapath through bhf_pkg::cmd_t.
module bhf_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [bhf_pkg::SIDE_W-1:0] side,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       final_row,
  output logic                       out_valid,
  input  logic                       out_ready,
  input  bhf_pkg::stat_t             stat,
  output bhf_pkg::cmd_t              cmd
);

  bhf_pkg::state_t state, state_next;
  logic [bhf_pkg::SIDE_W-1:0] row, row_next;
  logic first, first_next;
  logic in_acc;
  logic row_last;

  assign in_acc   = in_valid && (state == bhf_pkg::ST_LOAD);
  assign row_last = (row == side - bhf_pkg::SIDE_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bhf_pkg::ST_LOAD;
      row   <= '0;
      first <= 1'b0;
    end else begin
      state <= state_next;
      row   <= row_next;
      first <= first_next;
    end
  end

  always_comb begin
    state_next = state;
    row_next   = row;
    first_next = first;
    case (state)
      bhf_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (row < side) row_next = row + bhf_pkg::SIDE_W'(1);
          if (final_row) begin
            row_next   = '0;
            first_next = 1'b1;
            state_next = bhf_pkg::ST_PRIME;
          end
        end
      end
      bhf_pkg::ST_PRIME:  state_next = bhf_pkg::ST_WINDOW;
      bhf_pkg::ST_WINDOW: begin
        row_next   = '0;
        state_next = bhf_pkg::ST_ROW;
      end
      bhf_pkg::ST_ROW: begin
        if (row_last) begin
          row_next   = '0;
          first_next = 1'b0;
          state_next = stat.changed_any ? bhf_pkg::ST_PRIME : bhf_pkg::ST_EMIT_RD;
        end else begin
          row_next = row + bhf_pkg::SIDE_W'(1);
        end
      end
      bhf_pkg::ST_EMIT_RD: state_next = bhf_pkg::ST_EMIT_LD;
      bhf_pkg::ST_EMIT_LD: state_next = bhf_pkg::ST_EMIT_WAIT;
      bhf_pkg::ST_EMIT_WAIT: begin
        if (out_ready) begin
          if (row_last) begin
            row_next   = '0;
            state_next = bhf_pkg::ST_LOAD;
          end else begin
            row_next   = row + bhf_pkg::SIDE_W'(1);
            state_next = bhf_pkg::ST_EMIT_LD;
          end
        end
      end
      default: state_next = bhf_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state)
      bhf_pkg::ST_LOAD: begin
        in_ready      = 1'b1;
        cmd.wall_we   = in_acc && (row < side);
        cmd.wall_addr = row;
      end
      bhf_pkg::ST_PRIME: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = '0;
      end
      bhf_pkg::ST_WINDOW: begin
        // Row 0 enters the window; row 1 is fetched behind it.
        cmd.win_load = 1'b1;
        cmd.seed     = first;
        cmd.in_edge  = 1'b1;
        cmd.rd_en    = bhf_pkg::SIDE_W'(1) < side;
        cmd.rd_addr  = bhf_pkg::SIDE_W'(1);
      end
      bhf_pkg::ST_ROW: begin
        // The read data holds the row below the current one.
        cmd.row_step   = 1'b1;
        cmd.seed       = first;
        cmd.reach_addr = row;
        cmd.dn_valid   = (row + bhf_pkg::SIDE_W'(1)) < side;
        cmd.in_edge    = (row + bhf_pkg::SIDE_W'(2)) == side;
        cmd.rd_en      = (row + bhf_pkg::SIDE_W'(2)) < side;
        cmd.rd_addr    = row + bhf_pkg::SIDE_W'(2);
      end
      bhf_pkg::ST_EMIT_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = row;
      end
      bhf_pkg::ST_EMIT_LD: begin
        cmd.out_load = 1'b1;
        cmd.last     = row_last;
      end
      bhf_pkg::ST_EMIT_WAIT: begin
        out_valid   = 1'b1;
        cmd.rd_en   = out_ready && !row_last;
        cmd.rd_addr = row + bhf_pkg::SIDE_W'(1);
      end
      default: cmd = '0;
    endcase
  end

endmodule

/* rtl/bhf_datapath.sv */
// Datapath for the binary hole fill block: wall and reach memories, the three-row
// propagation window and the output word register. Depends on bhf_pkg.
module bhf_datapath #(
  parameter int MAX_SIDE = bhf_pkg::DEF_MAX_SIDE
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [bhf_pkg::SIDE_W-1:0] side,
  input  logic [bhf_pkg::ROW_W-1:0]  row_bits,
  input  bhf_pkg::cmd_t              cmd,
  output bhf_pkg::stat_t             stat,
  output logic [bhf_pkg::ROW_W-1:0]  wall_bits,
  output logic [bhf_pkg::ROW_W-1:0]  fill_bits,
  output logic                       last_out_row
);

  localparam int AW = $clog2(MAX_SIDE);

  logic [bhf_pkg::ROW_W-1:0] wall_mem  [MAX_SIDE];
  logic [bhf_pkg::ROW_W-1:0] reach_mem [MAX_SIDE];
  logic [bhf_pkg::ROW_W-1:0] rd_wall, rd_reach;

  logic [bhf_pkg::ROW_W-1:0] mask, edge_cols;
  logic [bhf_pkg::ROW_W-1:0] in_open, in_reach;
  logic [bhf_pkg::ROW_W-1:0] up_r, cur_r, cur_w;
  logic [bhf_pkg::ROW_W-1:0] dn, grow;
  logic changed, row_changed;

  assign mask      = bhf_pkg::column_mask(side);
  assign edge_cols = (bhf_pkg::ROW_W'(1) | (bhf_pkg::ROW_W'(1) << (side - bhf_pkg::SIDE_W'(1))))
                     & mask;

  always_ff @(posedge clk) begin
    if (cmd.wall_we) wall_mem[cmd.wall_addr[AW-1:0]] <= row_bits & mask;
    if (cmd.rd_en) rd_wall <= wall_mem[cmd.rd_addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.row_step) reach_mem[cmd.reach_addr[AW-1:0]] <= grow;
    if (cmd.rd_en) rd_reach <= reach_mem[cmd.rd_addr[AW-1:0]];
  end

  // On the first pass the border seed replaces the stored reach of the incoming row.
  assign in_open  = ~rd_wall & mask;
  assign in_reach = cmd.seed ? (cmd.in_edge ? in_open : (in_open & edge_cols)) : rd_reach;

  assign dn   = cmd.dn_valid ? in_reach : '0;
  assign grow = (cur_r | (cur_r << 1) | (cur_r >> 1) | up_r | dn) & ~cur_w & mask;
  assign row_changed = (grow != cur_r);

  assign stat.changed_any = changed || row_changed;

  always_ff @(posedge clk) begin
    if (rst) begin
      changed <= 1'b0;
    end else if (cmd.win_load) begin
      changed <= 1'b0;
    end else if (cmd.row_step) begin
      changed <= changed || row_changed;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.win_load) begin
      up_r  <= '0;
      cur_r <= in_reach;
      cur_w <= rd_wall;
    end else if (cmd.row_step) begin
      up_r  <= grow;
      cur_r <= in_reach;
      cur_w <= rd_wall;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      wall_bits    <= rd_wall & mask;
      fill_bits    <= ~rd_wall & ~rd_reach & mask;
      last_out_row <= cmd.last;
    end
  end

endmodule

/* rtl/binary_hole_fill.sv */
// Top level of the binary hole fill block: configuration register, controller and datapath.
// Depends on bhf_pkg, bhf_ctrl and bhf_datapath.
//
// Rows of a square binary image (1 = wall, 0 = open) are taken one word per cycle. The
// word with final_row set starts the fill: open cells 4-connected to the border are
// found by propagation passes over the stored image, and every open cell they cannot
// reach is reported in fill_bits. A pass walks the rows through a three-row window fed
// by one read port on each row memory. Passes repeat until one changes nothing: at least
// one and at most about the length of the longest open path. The image then leaves as
// side output words, each held until out_ready takes it. No input word is taken from
// the final row until the last output word has been taken.
module binary_hole_fill #(
  parameter int MAX_SIDE = bhf_pkg::DEF_MAX_SIDE
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [bhf_pkg::SIDE_W-1:0] cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [bhf_pkg::ROW_W-1:0]  row_bits,
  input  logic                       final_row,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [bhf_pkg::ROW_W-1:0]  wall_bits,
  output logic [bhf_pkg::ROW_W-1:0]  fill_bits,
  output logic                       last_out_row
);

  logic [bhf_pkg::SIDE_W-1:0] side_length;
  logic [bhf_pkg::SIDE_W-1:0] side;
  bhf_pkg::cmd_t  cmd;
  bhf_pkg::stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      side_length <= bhf_pkg::SIDE_RESET;
    end else if (cfg_we) begin
      side_length <= cfg_wdata;
    end
  end

  assign side = bhf_pkg::side_in_use(side_length, MAX_SIDE);

  bhf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .side      (side),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .final_row (final_row),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bhf_datapath #(
    .MAX_SIDE (MAX_SIDE)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .side         (side),
    .row_bits     (row_bits),
    .cmd          (cmd),
    .stat         (stat),
    .wall_bits    (wall_bits),
    .fill_bits    (fill_bits),
    .last_out_row (last_out_row)
  );

  // Loading and emission never overlap.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while an output word is pending");

  // A final row closes the input until the image has been emitted.
  a_final_closes: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && final_row) |=> (!in_ready && !out_valid))
    else $error("input still open after final row");

  // Taking the last output word returns the block to loading.
  a_last_reopens: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_out_row) |=> (in_ready && !out_valid))
    else $error("block did not return to loading after last word");

endmodule
